FILE: rtl/slz_pkg.sv
// types and constants shared by the short lz image decompressor
package slz_pkg;

    typedef struct packed {
        logic        func;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        logic [1:0]  status;
        logic        done_res;
    } t_out_item;

    typedef struct packed {
        logic [11:0] stride_bytes;
        logic [27:0] size_bytes;
        logic [15:0] flag_budget;
    } t_cfg;

    // item kinds
    localparam logic FUNC_FLAG    = 1'b0;
    localparam logic FUNC_LITERAL = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OUT_FAR    = 2'd1;
    localparam logic [1:0] ST_LIT_FAR    = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_STRIDE = 2'd0;
    localparam logic [1:0] CFG_IMAGE_ROWS = 2'd1;
    localparam logic [1:0] CFG_FLAG_COUNT = 2'd2;

    localparam logic [11:0] STRIDE_RESET = 12'd512;
    localparam logic [15:0] ROWS_RESET   = 16'd1;
    localparam logic [15:0] FLAGS_RESET  = 16'hFFFF;
    localparam logic [27:0] SIZE_RESET   = 28'd512;

    // flag byte fields
    localparam logic [7:0] FLAG_KIND_MASK = 8'hF0;
    localparam logic [7:0] FLAG_COPY_HI   = 8'h80;
    localparam logic [7:0] FLAG_COPY_LO   = 8'h40;
    localparam logic [7:0] FLAG_SEL_MASK  = 8'h30;
    localparam logic [7:0] FLAG_LEN_MASK  = 8'h0F;
    localparam logic [7:0] FLAG_LIT_BIAS  = 8'h0F;
    localparam int         FLAG_SEL_SHIFT = 4;

    // copy distance selections
    localparam logic [1:0] SEL_ONE       = 2'd0;
    localparam logic [1:0] SEL_ROW       = 2'd1;
    localparam logic [1:0] SEL_ROW_PLUS  = 2'd2;
    localparam logic [1:0] SEL_ROW_MINUS = 2'd3;

    localparam logic [8:0] LIT_COUNT_MAX = 9'd256;

endpackage

FILE: rtl/slz_ram.sv
// generic single write port, single read port ram with registered read
module slz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/slz_core.sv
// decode sequencer with output and literal history memories
module slz_core #(
    parameter int OUT_HISTORY_DEPTH = 2048,
    parameter int LIT_HISTORY_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slz_pkg::t_in_item  i_in_item,
    input  slz_pkg::t_cfg      i_cfg,
    input  logic               i_out_free,
    output logic               o_res_load,
    output slz_pkg::t_out_item o_res
);
    import slz_pkg::*;

    localparam int OW  = $clog2(OUT_HISTORY_DEPTH);
    localparam int AW  = OW + 1;
    localparam int LW  = $clog2(LIT_HISTORY_DEPTH);
    localparam int LAW = LW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CREAD,
        S_CWRITE,
        S_LREAD,
        S_LEMIT
    } t_state;

    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [4:0]  r_pending, n_pending;
    logic [26:0] r_out_count, n_out_count;
    logic [8:0]  r_lit_count, n_lit_count;
    logic [15:0] r_flags, n_flags;
    logic [OW-1:0] r_out_wp, n_out_wp;
    logic [LW-1:0] r_lit_wp, n_lit_wp;
    logic [AW-1:0] r_dist, n_dist;
    logic [3:0]  r_left, n_left;
    logic [7:0]  r_back, n_back;

    logic [7:0]  w_flag;
    logic        w_is_run;
    logic        w_is_copy;
    logic [1:0]  w_sel;
    logic [3:0]  w_len;
    logic [7:0]  w_back;
    logic [10:0] w_half;
    logic [11:0] w_dist;
    logic        w_copy_bad;
    logic        w_lit_bad;
    logic        w_done_cur;

    logic [AW-1:0]  w_out_diff;
    logic [OW-1:0]  w_out_rp;
    logic [LAW-1:0] w_lit_diff;
    logic [LW-1:0]  w_lit_rp;

    logic        w_out_we;
    logic [15:0] w_out_wdata;
    logic [15:0] w_out_rdata;
    logic        w_lit_we;
    logic [15:0] w_lit_rdata;

    logic        w_res_load;
    logic [15:0] w_res_sample;
    logic        w_res_last;
    logic [1:0]  w_res_status;
    logic        w_res_done;

    // flag decode
    assign w_flag    = r_item.value[7:0];
    assign w_is_run  = (w_flag & FLAG_KIND_MASK) == 8'd0;
    assign w_is_copy = ((w_flag & FLAG_COPY_HI) != 8'd0) && ((w_flag & FLAG_COPY_LO) != 8'd0);
    assign w_sel     = 2'((w_flag & FLAG_SEL_MASK) >> FLAG_SEL_SHIFT);
    assign w_len     = 4'(w_flag & FLAG_LEN_MASK);
    assign w_back    = w_flag - FLAG_LIT_BIAS;
    assign w_half    = i_cfg.stride_bytes[11:1];

    always_comb begin
        unique case (w_sel)
            SEL_ONE:       w_dist = 12'd1;
            SEL_ROW:       w_dist = {1'b0, w_half};
            SEL_ROW_PLUS:  w_dist = {1'b0, w_half} + 12'd1;
            SEL_ROW_MINUS: w_dist = {1'b0, w_half} - 12'd1;
            default:       w_dist = 12'd1;
        endcase
    end

    // row minus one with a zero row wraps, so it is caught apart from zero
    assign w_copy_bad = (w_dist == 12'd0)
                     || ((w_sel == SEL_ROW_MINUS) && (w_half == 11'd0))
                     || (27'(w_dist) > r_out_count)
                     || (13'(w_dist) > 13'(OUT_HISTORY_DEPTH));

    assign w_lit_bad = ({1'b0, w_back} > r_lit_count)
                    || ({1'b0, w_back} > 9'(LIT_HISTORY_DEPTH));

    assign w_done_cur = (r_pending == 5'd0)
                     && (({r_out_count, 1'b0} >= i_cfg.size_bytes)
                         || (r_flags >= i_cfg.flag_budget));

    // history read addresses, wrapped into the memory depth
    assign w_out_diff = {1'b0, r_out_wp} - r_dist;
    assign w_out_rp   = w_out_diff[AW-1] ? OW'(w_out_diff + AW'(OUT_HISTORY_DEPTH))
                                         : OW'(w_out_diff);
    assign w_lit_diff = {1'b0, r_lit_wp} - LAW'(r_back);
    assign w_lit_rp   = w_lit_diff[LAW-1] ? LW'(w_lit_diff + LAW'(LIT_HISTORY_DEPTH))
                                          : LW'(w_lit_diff);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_pending   = r_pending;
        n_out_count = r_out_count;
        n_lit_count = r_lit_count;
        n_flags     = r_flags;
        n_out_wp    = r_out_wp;
        n_lit_wp    = r_lit_wp;
        n_dist      = r_dist;
        n_left      = r_left;
        n_back      = r_back;

        w_res_load   = 1'b0;
        w_res_sample = 16'd0;
        w_res_last   = 1'b1;
        w_res_status = ST_OK;
        w_out_we     = 1'b0;
        w_out_wdata  = r_item.value;
        w_lit_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done_cur) begin
                    if (i_out_free) begin
                        w_res_load   = 1'b1;
                        w_res_status = ST_UNEXPECTED;
                        n_state      = S_IDLE;
                    end
                end else if (r_item.func == FUNC_LITERAL) begin
                    if (i_out_free) begin
                        w_res_load = 1'b1;
                        n_state    = S_IDLE;
                        if (r_pending == 5'd0) begin
                            w_res_status = ST_UNEXPECTED;
                        end else begin
                            w_res_sample = r_item.value;
                            w_lit_we     = 1'b1;
                            w_out_we     = 1'b1;
                            n_pending    = r_pending - 5'd1;
                            n_lit_wp     = (r_lit_wp == LW'(LIT_HISTORY_DEPTH - 1))
                                         ? '0 : r_lit_wp + LW'(1);
                            n_lit_count  = (r_lit_count == LIT_COUNT_MAX)
                                         ? r_lit_count : r_lit_count + 9'd1;
                            n_out_wp     = (r_out_wp == OW'(OUT_HISTORY_DEPTH - 1))
                                         ? '0 : r_out_wp + OW'(1);
                            n_out_count  = (r_out_count == '1)
                                         ? r_out_count : r_out_count + 27'd1;
                        end
                    end
                end else if (r_pending != 5'd0) begin
                    if (i_out_free) begin
                        w_res_load   = 1'b1;
                        w_res_status = ST_UNEXPECTED;
                        n_state      = S_IDLE;
                    end
                end else if (w_is_run) begin
                    n_flags   = r_flags + 16'd1;
                    n_pending = 5'(w_len) + 5'd1;
                    n_state   = S_IDLE;
                end else if (w_is_copy) begin
                    if (w_copy_bad) begin
                        if (i_out_free) begin
                            n_flags      = r_flags + 16'd1;
                            w_res_load   = 1'b1;
                            w_res_status = ST_OUT_FAR;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        n_flags = r_flags + 16'd1;
                        n_dist  = AW'(w_dist);
                        n_left  = w_len;
                        n_state = S_CREAD;
                    end
                end else begin
                    if (w_lit_bad) begin
                        if (i_out_free) begin
                            n_flags      = r_flags + 16'd1;
                            w_res_load   = 1'b1;
                            w_res_status = ST_LIT_FAR;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        n_flags = r_flags + 16'd1;
                        n_back  = w_back;
                        n_state = S_LREAD;
                    end
                end
            end
            S_CREAD: begin
                n_state = S_CWRITE;
            end
            S_CWRITE: begin
                // read data holds here until the output register frees up
                if (i_out_free) begin
                    w_res_load   = 1'b1;
                    w_res_sample = w_out_rdata;
                    w_res_last   = (r_left == 4'd0);
                    w_out_we     = 1'b1;
                    w_out_wdata  = w_out_rdata;
                    n_out_wp     = (r_out_wp == OW'(OUT_HISTORY_DEPTH - 1))
                                 ? '0 : r_out_wp + OW'(1);
                    n_out_count  = (r_out_count == '1) ? r_out_count : r_out_count + 27'd1;
                    n_left       = r_left - 4'd1;
                    n_state      = (r_left == 4'd0) ? S_IDLE : S_CREAD;
                end
            end
            S_LREAD: begin
                n_state = S_LEMIT;
            end
            S_LEMIT: begin
                if (i_out_free) begin
                    w_res_load   = 1'b1;
                    w_res_sample = w_lit_rdata;
                    w_out_we     = 1'b1;
                    w_out_wdata  = w_lit_rdata;
                    n_out_wp     = (r_out_wp == OW'(OUT_HISTORY_DEPTH - 1))
                                 ? '0 : r_out_wp + OW'(1);
                    n_out_count  = (r_out_count == '1) ? r_out_count : r_out_count + 27'd1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // done as seen after this transaction's updates
        w_res_done = (n_pending == 5'd0)
                  && (({n_out_count, 1'b0} >= i_cfg.size_bytes)
                      || (n_flags >= i_cfg.flag_budget));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_item      <= '0;
            r_pending   <= '0;
            r_out_count <= '0;
            r_lit_count <= '0;
            r_flags     <= '0;
            r_out_wp    <= '0;
            r_lit_wp    <= '0;
            r_dist      <= '0;
            r_left      <= '0;
            r_back      <= '0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_pending   <= n_pending;
            r_out_count <= n_out_count;
            r_lit_count <= n_lit_count;
            r_flags     <= n_flags;
            r_out_wp    <= n_out_wp;
            r_lit_wp    <= n_lit_wp;
            r_dist      <= n_dist;
            r_left      <= n_left;
            r_back      <= n_back;
        end
    end

    slz_ram #(
        .WIDTH (16),
        .DEPTH (OUT_HISTORY_DEPTH)
    ) u_out_hist (
        .i_clk   (i_clk),
        .i_we    (w_out_we),
        .i_waddr (r_out_wp),
        .i_wdata (w_out_wdata),
        .i_re    (r_state == S_CREAD),
        .i_raddr (w_out_rp),
        .o_rdata (w_out_rdata)
    );

    slz_ram #(
        .WIDTH (16),
        .DEPTH (LIT_HISTORY_DEPTH)
    ) u_lit_hist (
        .i_clk   (i_clk),
        .i_we    (w_lit_we),
        .i_waddr (r_lit_wp),
        .i_wdata (r_item.value),
        .i_re    (r_state == S_LREAD),
        .i_raddr (w_lit_rp),
        .o_rdata (w_lit_rdata)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_res_load      = w_res_load;
    assign o_res.sample    = w_res_sample;
    assign o_res.last      = w_res_last;
    assign o_res.status    = w_res_status;
    assign o_res.done_res  = w_res_done;

endmodule

FILE: rtl/short_lz_image_decompressor.sv
// top level: configuration registers, output register and decode core
//
// channel  direction  handshake                     payload
// in       input      i_in_valid / o_in_stall       i_in_item (func, value)
// out      output     o_out_valid / i_out_stall     o_out_item (sample, last, status, done_res)
// cfg      input      i_cfg_we                      i_cfg_index, i_cfg_data
//
// one item is taken at a time: a flag or literal is handled in the execute state, a
// literal back-reference reads the literal history before its result, and a copy run
// makes a read-then-write turn on the output history memory for each short.
// histories need no clearing pass after reset; the block takes items right away.
// a stalled output holds its result in the output register; the core waits only when
// that register is full and not being taken.
module short_lz_image_decompressor #(
    parameter int OUT_HISTORY_DEPTH = 2048,
    parameter int LIT_HISTORY_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slz_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output slz_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import slz_pkg::*;

    logic [11:0] r_stride;
    logic [15:0] r_rows;
    logic [15:0] r_flag_budget;
    logic [27:0] r_size;
    logic        r_out_valid;
    t_out_item   r_out_item;

    t_cfg        w_cfg;
    logic        w_out_free;
    logic        w_res_load;
    t_out_item   w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride      <= STRIDE_RESET;
            r_rows        <= ROWS_RESET;
            r_flag_budget <= FLAGS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_STRIDE: r_stride      <= i_cfg_data[11:0];
                CFG_IMAGE_ROWS: r_rows        <= i_cfg_data;
                CFG_FLAG_COUNT: r_flag_budget <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output size in bytes, registered from the stride and row registers that a configuration write sets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else begin
            r_size <= 28'(r_stride) * 28'(r_rows);
        end
    end

    assign w_cfg.stride_bytes = r_stride;
    assign w_cfg.size_bytes   = r_size;
    assign w_cfg.flag_budget  = r_flag_budget;

    assign w_out_free = !r_out_valid || !i_out_stall;

    slz_core #(
        .OUT_HISTORY_DEPTH (OUT_HISTORY_DEPTH),
        .LIT_HISTORY_DEPTH (LIT_HISTORY_DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_cfg      (w_cfg),
        .i_out_free (w_out_free),
        .o_res_load (w_res_load),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_item  <= '0;
        end else begin
            r_out_valid <= w_res_load || (r_out_valid && i_out_stall);
            if (w_res_load) begin
                r_out_item <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a held transaction");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in progress");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_load && (w_res.status != ST_OK)) |-> (w_res.last && (w_res.sample == 16'd0)))
        else $error("error result not a lone zero transaction");
`endif

endmodule
